// File: sv/spamd_pkg.sv
// Package with the item types and constants of the add / multiply / divide unit.
`default_nettype none
package spamd_pkg;
   localparam int unsigned WORD_BITS = 32;
   localparam int unsigned EXP_BITS = 8;
   localparam logic [EXP_BITS-1:0] EXP_BIAS = 8'd127;
   localparam int unsigned GUARD_BITS = 3;

   typedef enum logic [1:0] {
      MODE_ADD = 2'd0,
      MODE_MUL = 2'd1,
      MODE_DIV = 2'd2,
      MODE_NONE = 2'd3
   } mode_type;

   typedef struct packed {
      logic [1:0] mode;
      logic [WORD_BITS-1:0] operand_a;
      logic [WORD_BITS-1:0] operand_b;
   } req_item_type;

   typedef struct packed {
      logic [WORD_BITS-1:0] result_word;
      logic divide_by_zero;
   } rsp_item_type;
endpackage
`default_nettype wire

// File: sv/single_precision_add_mul_div.sv
// Truncating floating-point add / multiply / divide unit with bit-serial datapath.
// A zero operand, exact cancellation, divide by zero or the unused mode goes straight from
// idle to the result; multiply takes one multiplier bit per cycle, divide forms one
// quotient bit per cycle, and add runs alignment shifts and then normalization shifts.
// One item at a time: req_stall holds off a new item until the result has been taken;
// reset clears control only.
`default_nettype none
module single_precision_add_mul_div
   import spamd_pkg::*;
#(
   parameter int unsigned FRACTION_BITS = 23
) (
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output logic              req_stall,
   input  wire req_item_type req_item,
   output logic              rsp_valid,
   input  wire logic         rsp_stall,
   output rsp_item_type      rsp_item
);
   localparam int unsigned FB = FRACTION_BITS;
   localparam int unsigned MW = FB + 1;          // mantissa with hidden one
   localparam int unsigned TOP = FB + GUARD_BITS;
   localparam int unsigned AW = TOP + 2;         // aligned sum width
   localparam int unsigned PW = 2 * MW;          // product width
   localparam int unsigned QN = FB + 3;          // quotient bits
   localparam int unsigned CW = $clog2(PW + 2);
   localparam int unsigned SGN = FB + EXP_BITS;  // sign position in a wide word
   localparam int unsigned XW = SGN + 1;

   typedef enum logic [2:0] {
      ST_IDLE, ST_ALIGN, ST_ADDNORM, ST_MUL, ST_DIV, ST_DONE
   } state_type;

   state_type state_ff, state_in;
   logic [1:0] mode_ff, mode_in;
   logic sa_ff, sa_in, sb_ff, sb_in;
   logic [EXP_BITS-1:0] ea_ff, ea_in;
   logic [MW-1:0] ma_ff, ma_in, mb_ff, mb_in;
   logic [AW-1:0] acc_ff, acc_in;       // add: big aligned; div: remainder
   logic [AW-1:0] sm_ff, sm_in;         // add: shifting small addend
   logic sticky_ff, sticky_in;
   logic [EXP_BITS-1:0] cnt_ff, cnt_in;
   logic [PW-1:0] prod_ff, prod_in;
   logic [QN-1:0] quo_ff, quo_in;
   logic [CW-1:0] step_ff, step_in;
   logic [WORD_BITS-1:0] res_ff, res_in;
   logic dz_ff, dz_in;
   logic subtract_ff, subtract_in;

   // Operand fields, with bits above the word read as zero.
   logic [XW-1:0] wa, wb;
   logic za, zb;
   assign wa = XW'(req_item.operand_a);
   assign wb = XW'(req_item.operand_b);
   assign za = (wa[SGN-1:0] == '0);
   assign zb = (wb[SGN-1:0] == '0);

   function automatic logic [WORD_BITS-1:0] pack(input logic s, input logic [EXP_BITS-1:0] e,
                                                 input logic [FB-1:0] f);
      logic [XW-1:0] w;
      begin
         w = {s, e, f};
         return WORD_BITS'(w);
      end
   endfunction

   logic [EXP_BITS-1:0] ea_w, eb_w;
   logic [MW-1:0] ma_w, mb_w;
   logic a_big;
   logic [AW:0] sum_w;
   logic [AW:0] rem_sh;
   assign ea_w = wa[SGN-1:FB];
   assign eb_w = wb[SGN-1:FB];
   assign ma_w = {1'b1, wa[FB-1:0]};
   assign mb_w = {1'b1, wb[FB-1:0]};
   assign a_big = (ea_w > eb_w) || (ea_w == eb_w && ma_w >= mb_w);
   assign sum_w = {1'b0, acc_ff} + {1'b0, sm_ff};
   assign rem_sh = {acc_ff, 1'b0};

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_DONE);
   assign rsp_item.result_word = res_ff;
   assign rsp_item.divide_by_zero = dz_ff;

   // Sequencer: each serial arm advances the datapath by one digit; idle and done run the handshakes.
   always_comb begin
      state_in = state_ff; mode_in = mode_ff; sa_in = sa_ff; sb_in = sb_ff;
      ea_in = ea_ff; ma_in = ma_ff; mb_in = mb_ff; acc_in = acc_ff; sm_in = sm_ff;
      sticky_in = sticky_ff; cnt_in = cnt_ff; prod_in = prod_ff; quo_in = quo_ff;
      step_in = step_ff; res_in = res_ff; dz_in = dz_ff; subtract_in = subtract_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mode_in = req_item.mode;
               sa_in = wa[SGN]; sb_in = wb[SGN];
               dz_in = 1'b0;
               step_in = '0;
               case (mode_type'(req_item.mode))
                  MODE_ADD: begin
                     if (za && zb) begin
                        res_in = '0; state_in = ST_DONE;
                     end else if (za) begin
                        res_in = req_item.operand_b; state_in = ST_DONE;
                     end else if (zb) begin
                        res_in = req_item.operand_a; state_in = ST_DONE;
                     end else if (ea_w == eb_w && ma_w == mb_w && wa[SGN] != wb[SGN]) begin
                        res_in = '0; state_in = ST_DONE;
                     end else begin
                        sa_in = a_big ? wa[SGN] : wb[SGN];
                        subtract_in = wa[SGN] ^ wb[SGN];
                        ea_in = a_big ? ea_w : eb_w;
                        acc_in = AW'({(a_big ? ma_w : mb_w), GUARD_BITS'(0)});
                        sm_in = AW'({(a_big ? mb_w : ma_w), GUARD_BITS'(0)});
                        cnt_in = a_big ? ea_w - eb_w : eb_w - ea_w;
                        sticky_in = 1'b0;
                        state_in = ST_ALIGN;
                     end
                  end
                  MODE_MUL: begin
                     if (za || zb) begin
                        res_in = pack(wa[SGN] ^ wb[SGN], '0, '0); state_in = ST_DONE;
                     end else begin
                        ea_in = ea_w + eb_w - EXP_BIAS;
                        ma_in = ma_w; mb_in = mb_w; prod_in = '0;
                        state_in = ST_MUL;
                     end
                  end
                  MODE_DIV: begin
                     if (zb) begin
                        res_in = '0; dz_in = 1'b1; state_in = ST_DONE;
                     end else if (za) begin
                        res_in = pack(wa[SGN] ^ wb[SGN], '0, '0); state_in = ST_DONE;
                     end else begin
                        ea_in = ea_w - eb_w + EXP_BIAS;
                        mb_in = mb_w;
                        acc_in = AW'(ma_w);
                        quo_in = '0;
                        state_in = ST_DIV;
                     end
                  end
                  default: begin
                     res_in = '0; state_in = ST_DONE;
                  end
               endcase
            end
         end
         // Shift the small addend right one place a cycle, collecting sticky, then add or subtract.
         ST_ALIGN: begin
            if (cnt_ff == '0 || sm_ff == '0) begin
               if (subtract_ff) begin
                  acc_in = acc_ff - sm_ff - AW'(sticky_ff);
                  cnt_in = EXP_BITS'(TOP);
               end else begin
                  acc_in = sum_w[AW-1:0];
                  if (sum_w[TOP+1]) begin
                     ea_in = ea_ff + 1'b1;
                     acc_in = sum_w[AW-1:0] >> 1;
                  end
               end
               state_in = ST_ADDNORM;
            end else begin
               sticky_in = sticky_ff | sm_ff[0];
               sm_in = sm_ff >> 1;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         // Normalize: shift left one place a cycle until the hidden one reaches TOP.
         ST_ADDNORM: begin
            if (acc_ff[TOP]) begin
               res_in = pack(sa_ff, ea_ff - (subtract_ff ? EXP_BITS'(TOP) - cnt_ff : '0),
                             acc_ff[TOP-1:GUARD_BITS]);
               state_in = ST_DONE;
            end else begin
               acc_in = acc_ff << 1;
               cnt_in = cnt_ff - 1'b1;
            end
         end
         // Shift-add multiply, one multiplier bit a cycle from the top.
         ST_MUL: begin
            if (step_ff == CW'(MW)) begin
               if (prod_ff[PW-1]) begin
                  res_in = pack(sa_ff ^ sb_ff, ea_ff + 1'b1, prod_ff[PW-2 -: FB]);
               end else begin
                  res_in = pack(sa_ff ^ sb_ff, ea_ff, prod_ff[PW-3 -: FB]);
               end
               state_in = ST_DONE;
            end else begin
               prod_in = (prod_ff << 1) + (mb_ff[MW-1] ? PW'(ma_ff) : '0);
               mb_in = mb_ff << 1;
               step_in = step_ff + 1'b1;
            end
         end
         // Restoring division, one quotient bit a cycle.
         ST_DIV: begin
            if (step_ff == CW'(QN)) begin
               if (quo_ff[QN-1]) res_in = pack(sa_ff ^ sb_ff, ea_ff, quo_ff[QN-2 -: FB]);
               else res_in = pack(sa_ff ^ sb_ff, ea_ff - 1'b1, quo_ff[QN-3 -: FB]);
               state_in = ST_DONE;
            end else begin
               if (step_ff == '0) begin
                  if (acc_ff >= AW'(mb_ff)) begin
                     acc_in = acc_ff - AW'(mb_ff); quo_in = QN'(1);
                  end
               end else if (rem_sh >= (AW+1)'(mb_ff)) begin
                  acc_in = AW'(rem_sh - (AW+1)'(mb_ff)); quo_in = {quo_ff[QN-2:0], 1'b1};
               end else begin
                  acc_in = rem_sh[AW-1:0]; quo_in = {quo_ff[QN-2:0], 1'b0};
               end
               step_in = step_ff + 1'b1;
            end
         end
         ST_DONE: begin
            if (!rsp_stall) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mode_ff <= mode_in; sa_ff <= sa_in; sb_ff <= sb_in; ea_ff <= ea_in;
      ma_ff <= ma_in; mb_ff <= mb_in; acc_ff <= acc_in; sm_ff <= sm_in;
      sticky_ff <= sticky_in; cnt_ff <= cnt_in; prod_ff <= prod_in; quo_ff <= quo_in;
      step_ff <= step_in; res_ff <= res_in; dz_ff <= dz_in; subtract_ff <= subtract_in;
   end

   // The error flag appears only on a divide.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dz_ff |-> mode_ff == MODE_DIV) else $error("flag on non-divide");
   // A flagged item carries a zero word.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && dz_ff |-> res_ff == '0) else $error("nonzero word with flag");
   // A waiting result holds while stalled.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(res_ff)) else $error("result lost");
endmodule
`default_nettype wire

// File: test/tb_single_precision_add_mul_div.sv
// Testbench for the truncating add / multiply / divide unit, checked against a bit-exact predictor.
`timescale 1ns / 100ps
`default_nettype none

// Scoreboard: keeps expected results in arrival order and compares them with the block's output.
class float_result_board;
   spamd_pkg::rsp_item_type pending_q[$];
   int unsigned mismatch_count;
   int unsigned orphan_count;
   int unsigned checked_count;

   // The operand is zero when every bit below the sign is clear.
   static function bit is_zero_word(logic [31:0] w);
      return w[30:0] == 31'd0;
   endfunction

   static function logic [31:0] pack_word(logic s, logic [7:0] e, logic [22:0] f);
      return {s, e, f};
   endfunction

   // Truncating add with guard bits and a sticky borrow on subtraction.
   static function logic [31:0] add_words(logic [31:0] a, logic [31:0] b);
      logic [7:0] ea, eb, big_e, diff;
      logic [23:0] ma, mb, big_m, small_m;
      logic [63:0] aw, bw, sum, d, f, sticky;
      logic big_s, a_big;
      int p;
      if (is_zero_word(a) && is_zero_word(b)) return 32'd0;
      if (is_zero_word(a)) return b;
      if (is_zero_word(b)) return a;
      ea = a[30:23]; eb = b[30:23];
      ma = {1'b1, a[22:0]}; mb = {1'b1, b[22:0]};
      a_big = (ea > eb) || (ea == eb && ma >= mb);
      big_e = a_big ? ea : eb;
      diff = a_big ? ea - eb : eb - ea;
      big_m = a_big ? ma : mb;
      small_m = a_big ? mb : ma;
      big_s = a_big ? a[31] : b[31];
      aw = 64'(big_m) << 3;
      if (diff >= 27) begin
         bw = 0;
         sticky = 1;
      end else begin
         bw = (64'(small_m) << 3) >> diff;
         sticky = (((64'(small_m) << 3) & ((64'd1 << diff) - 1)) != 0) ? 64'd1 : 64'd0;
      end
      if (a[31] == b[31]) begin
         sum = aw + bw;
         if (sum[27]) return pack_word(a[31], big_e + 8'd1, sum[26:4]);
         return pack_word(a[31], big_e, sum[25:3]);
      end
      if (ea == eb && ma == mb) return 32'd0;
      d = aw - bw - sticky;
      p = 0;
      for (int i = 0; i < 64; i++) if (d[i]) p = i;
      if (p >= 23) f = d >> (p - 23);
      else f = d << (23 - p);
      return pack_word(big_s, big_e + 8'(p) - 8'd26, f[22:0]);
   endfunction

   // Truncating multiply of the 24-bit significands.
   static function logic [31:0] multiply_words(logic [31:0] a, logic [31:0] b);
      logic s;
      logic [47:0] prod;
      logic [7:0] e;
      s = a[31] ^ b[31];
      if (is_zero_word(a) || is_zero_word(b)) return pack_word(s, 8'd0, 23'd0);
      prod = {1'b1, a[22:0]} * {1'b1, b[22:0]};
      e = a[30:23] + b[30:23] - 8'd127;
      if (prod[47]) return pack_word(s, e + 8'd1, prod[46:24]);
      return pack_word(s, e, prod[45:23]);
   endfunction

   // Restoring division to 25 fraction bits, then truncated.
   static function logic [31:0] divide_words(logic [31:0] a, logic [31:0] b);
      logic s;
      logic [63:0] rem, q, n, d;
      logic [7:0] e;
      s = a[31] ^ b[31];
      if (is_zero_word(a)) return pack_word(s, 8'd0, 23'd0);
      n = {1'b1, a[22:0]}; d = {1'b1, b[22:0]};
      rem = n; q = 0;
      if (rem >= d) begin q = 1; rem -= d; end
      for (int i = 0; i < 25; i++) begin
         rem <<= 1;
         q <<= 1;
         if (rem >= d) begin q[0] = 1'b1; rem -= d; end
      end
      e = a[30:23] - b[30:23] + 8'd127;
      if (q[25]) return pack_word(s, e, q[24:2]);
      return pack_word(s, e - 8'd1, q[23:1]);
   endfunction

   // Note one accepted input item and queue what it should produce.
   function void note_request(spamd_pkg::req_item_type req);
      spamd_pkg::rsp_item_type rsp;
      rsp = '0;
      case (spamd_pkg::mode_type'(req.mode))
         spamd_pkg::MODE_ADD: rsp.result_word = add_words(req.operand_a, req.operand_b);
         spamd_pkg::MODE_MUL: rsp.result_word = multiply_words(req.operand_a, req.operand_b);
         spamd_pkg::MODE_DIV: begin
            if (is_zero_word(req.operand_b)) rsp.divide_by_zero = 1'b1;
            else rsp.result_word = divide_words(req.operand_a, req.operand_b);
         end
         default: rsp = '0;
      endcase
      pending_q = {pending_q, rsp};
   endfunction

   // Compare one accepted result item with the oldest expectation.
   function void check_result(spamd_pkg::rsp_item_type got);
      spamd_pkg::rsp_item_type want;
      if (pending_q.size() == 0) begin
         orphan_count++;
         mismatch_count++;
         if (mismatch_count <= 10) $display("Unexpected result item %h", got);
         return;
      end
      want = pending_q.pop_front();
      checked_count++;
      if (got.result_word !== want.result_word || got.divide_by_zero !== want.divide_by_zero)
      begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("Mismatch: expected word %h dbz %b, got word %h dbz %b",
               want.result_word, want.divide_by_zero, got.result_word, got.divide_by_zero);
      end
   endfunction
endclass

module tb_single_precision_add_mul_div;
   import spamd_pkg::*;

   logic clock;
   logic reset;
   logic req_valid;
   logic req_stall;
   req_item_type req_item;
   logic rsp_valid;
   logic rsp_stall;
   rsp_item_type rsp_item;

   float_result_board board;
   bit hold_off_active;
   bit sending_done;
   int unsigned sent_count;

   single_precision_add_mul_div DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_item(req_item),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_item(rsp_item)
   );

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Offer one item and hold it until the block takes it, then idle a random gap if with_gap is set.
   task automatic send_item(logic [1:0] mode, logic [31:0] a, logic [31:0] b, bit with_gap);
      int unsigned gap;
      req_item <= '{mode: mode, operand_a: a, operand_b: b};
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      board.note_request('{mode: mode, operand_a: a, operand_b: b});
      sent_count++;
      @(negedge clock);
      gap = with_gap ? $urandom_range(0, 14) : 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
   endtask

   // Random operand: mostly modest exponents, some anywhere, some zero.
   function automatic logic [31:0] random_operand();
      int unsigned pick;
      logic [31:0] w;
      pick = $urandom_range(0, 19);
      w = $urandom;
      if (pick == 0) w[30:0] = 31'd0;
      else if (pick < 14) w[30:23] = 8'($urandom_range(100, 154));
      return w;
   endfunction

   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (board.pending_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   // Stimulus.
   initial begin
      logic [31:0] a, b;
      logic [1:0] m;
      board = new();
      reset = 1'b1;
      req_valid = 1'b0;
      req_item = '0;
      sent_count = 0;
      sending_done = 0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed corner cases: zeros, cancellation, extremes, unused mode.
      send_item(MODE_ADD, 32'h0000_0000, 32'h8000_0000, 1);
      send_item(MODE_ADD, 32'h3F80_0000, 32'h0000_0000, 1);
      send_item(MODE_ADD, 32'h8000_0000, 32'hC040_0000, 1);
      send_item(MODE_ADD, 32'h3FC0_0000, 32'hBFC0_0000, 1);
      send_item(MODE_ADD, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
      send_item(MODE_ADD, 32'h7F00_0000, 32'h0080_0001, 1);
      send_item(MODE_ADD, 32'h3F80_0001, 32'hBF80_0000, 1);
      send_item(MODE_ADD, 32'h4000_0000, 32'hB3FF_FFFF, 1);
      send_item(MODE_MUL, 32'h0000_0000, 32'hBF80_0000, 1);
      send_item(MODE_MUL, 32'h8000_0000, 32'h3F80_0000, 1);
      send_item(MODE_MUL, 32'h3FFF_FFFF, 32'hBFFF_FFFF, 1);
      send_item(MODE_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1);
      send_item(MODE_MUL, 32'h0080_0000, 32'h0080_0000, 1);
      send_item(MODE_DIV, 32'h3F80_0000, 32'h0000_0000, 1);
      send_item(MODE_DIV, 32'hBF80_0000, 32'h8000_0000, 1);
      send_item(MODE_DIV, 32'h8000_0000, 32'h3F80_0000, 1);
      send_item(MODE_DIV, 32'h3FFF_FFFF, 32'h3F80_0000, 1);
      send_item(MODE_DIV, 32'h3F80_0000, 32'h3FFF_FFFF, 1);
      send_item(MODE_DIV, 32'h7FFF_FFFF, 32'h0080_0000, 1);
      send_item(MODE_DIV, 32'h0080_0000, 32'h7FFF_FFFF, 1);
      send_item(MODE_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1);
      send_item(MODE_NONE, 32'h0000_0000, 32'h0000_0000, 1);

      // Pause until every expected result is back.
      wait_for_drain();

      // Random items; a stretch without gaps lets the receiver hold-off back up the block.
      for (int i = 0; i < 1600; i++) begin
         m = 2'($urandom_range(0, 15) == 0 ? 3 : $urandom_range(0, 2));
         a = random_operand();
         b = $urandom_range(0, 3) == 0 ? a ^ 32'h8000_0000 : random_operand();
         if ($urandom_range(0, 3) != 0) b = random_operand();
         send_item(m, a, b, !(i >= 400 && i < 440) && (i % 200) >= 30);
         if (i == 800) wait_for_drain();
      end
      req_valid <= 1'b0;
      sending_done = 1;
   end

   // Receiver: random stalls, plus one long hold-off while the sender keeps offering.
   initial begin
      int unsigned waits;
      rsp_stall = 1'b1;
      hold_off_active = 0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (sent_count == 405 && !hold_off_active) begin
            hold_off_active = 1;
            rsp_stall <= 1'b1;
            repeat (300) @(negedge clock);
         end
         waits = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
         if (sent_count >= 1000 && sent_count < 1100) waits = 0;
         if (waits != 0) begin
            rsp_stall <= 1'b1;
            repeat (waits) @(negedge clock);
         end
         rsp_stall <= 1'b0;
         @(negedge clock);
      end
   end

   // Result monitor.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) board.check_result(rsp_item);
   end

   // End of run.
   initial begin
      wait (sending_done);
      while (board.pending_q.size() != 0) @(negedge clock);
      repeat (100) @(negedge clock);
      $display("Checked %0d result items from %0d add, multiply, divide and unused-mode items,",
         board.checked_count, sent_count);
      $display("including zero, cancellation, divide-by-zero and exponent-wrap cases.");
      if (board.mismatch_count == 0 && board.pending_q.size() == 0)
         $display("single_precision_add_mul_div test passed");
      else
         $display("single_precision_add_mul_div test failed");
      $finish;
   end

   // Timeout.
   initial begin
      #4000000;
      $display("single_precision_add_mul_div test failed");
      $finish;
   end
endmodule

`default_nettype wire
